@@ src/rssg_pkg.sv @@
package rssg_pkg;

	localparam int NUM_RELAYS = 4;
	localparam int IDX_W      = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
	localparam int PADDR_W    = 5;
	localparam int MASK_W     = 4;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_LOCK_ACTIVE = 3'd1,
		ST_LOCK_TRIG   = 3'd2,
		ST_COOLDOWN    = 3'd3,
		ST_CYCLE_LIMIT = 3'd4,
		ST_BAD_INDEX   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_LOCKOUT_MS  = 3'd0,
		REG_WINDOW_MS   = 3'd1,
		REG_MAX_CYCLES  = 3'd2,
		REG_MANUAL_ALW  = 3'd3,
		REG_COOLDOWN_MS = 3'd4,
		REG_COOLDOWN_MK = 3'd5
	} reg_idx_t;

	localparam logic [31:0]       RST_LOCKOUT_MS  = 32'd5000;
	localparam logic [31:0]       RST_WINDOW_MS   = 32'd60000;
	localparam logic [7:0]        RST_MAX_CYCLES  = 8'd6;
	localparam logic [7:0]        RST_MANUAL_ALW  = 8'd2;
	localparam logic [31:0]       RST_COOLDOWN_MS = 32'd180000;
	localparam logic [MASK_W-1:0] RST_COOLDOWN_MK = '0;

	typedef struct packed {
		logic [31:0]       lockout_ms;
		logic [31:0]       window_ms;
		logic [7:0]        max_cycles;
		logic [7:0]        manual_allowance;
		logic [31:0]       cooldown_ms;
		logic [MASK_W-1:0] cooldown_mask;
	} cfg_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] lim;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] diff;
		logic        lt;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_LOCK,
		S_WIN1,
		S_LIMIT,
		S_COOL,
		S_WIN2,
		S_MAXC,
		S_ON_WIN,
		S_ON_SET,
		S_CD1,
		S_CD2,
		S_DONE
	} state_t;

	// relays whose index is not below the mask width never take a cooldown
	function automatic logic needs_cd(input logic [MASK_W-1:0] mask, input logic [4:0] r);
		return (r < 5'(MASK_W)) && mask[r[1:0]];
	endfunction

endpackage

@@ src/rssg_if.sv @@
interface rssg_cmd_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [3:0]  relay_index;
	logic        turn_on;
	logic        force_req;
	logic [31:0] now_ms;

	modport source (output valid, func, relay_index, turn_on, force_req, now_ms, input ready);
	modport sink (input valid, func, relay_index, turn_on, force_req, now_ms, output ready);
endinterface

interface rssg_res_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  status;
	logic [3:0]  relays_on;
	logic [31:0] cooldown_left_ms;
	logic [7:0]  turn_on_count;

	modport source (output valid, accepted, status, relays_on, cooldown_left_ms,
		turn_on_count, input ready);
	modport sink (input valid, accepted, status, relays_on, cooldown_left_ms,
		turn_on_count, output ready);
endinterface

@@ src/rssg_alu.sv @@
module rssg_alu (
	input  rssg_pkg::alu_req_t req,
	output rssg_pkg::alu_rsp_t rsp
);

	logic [31:0] diff;

	// wrapped elapsed time and its compare against a length
	assign diff     = req.a - req.b;
	assign rsp.diff = diff;
	assign rsp.lt   = diff < req.lim;

endmodule

@@ src/rssg_regs.sv @@
module rssg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rssg_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output rssg_pkg::cfg_t               cfg
);

	rssg_pkg::cfg_t   cfg_q;
	rssg_pkg::reg_idx_t idx;
	logic             wr;

	assign idx    = rssg_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ms       <= rssg_pkg::RST_LOCKOUT_MS;
			cfg_q.window_ms        <= rssg_pkg::RST_WINDOW_MS;
			cfg_q.max_cycles       <= rssg_pkg::RST_MAX_CYCLES;
			cfg_q.manual_allowance <= rssg_pkg::RST_MANUAL_ALW;
			cfg_q.cooldown_ms      <= rssg_pkg::RST_COOLDOWN_MS;
			cfg_q.cooldown_mask    <= rssg_pkg::RST_COOLDOWN_MK;
		end else if (wr) begin
			case (idx)
				rssg_pkg::REG_LOCKOUT_MS:  cfg_q.lockout_ms       <= pwdata;
				rssg_pkg::REG_WINDOW_MS:   cfg_q.window_ms        <= pwdata;
				rssg_pkg::REG_MAX_CYCLES:  cfg_q.max_cycles       <= pwdata[7:0];
				rssg_pkg::REG_MANUAL_ALW:  cfg_q.manual_allowance <= pwdata[7:0];
				rssg_pkg::REG_COOLDOWN_MS: cfg_q.cooldown_ms      <= pwdata;
				rssg_pkg::REG_COOLDOWN_MK: cfg_q.cooldown_mask    <= pwdata[rssg_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rssg_pkg::REG_LOCKOUT_MS:  prdata = cfg_q.lockout_ms;
			rssg_pkg::REG_WINDOW_MS:   prdata = cfg_q.window_ms;
			rssg_pkg::REG_MAX_CYCLES:  prdata = {24'd0, cfg_q.max_cycles};
			rssg_pkg::REG_MANUAL_ALW:  prdata = {24'd0, cfg_q.manual_allowance};
			rssg_pkg::REG_COOLDOWN_MS: prdata = cfg_q.cooldown_ms;
			rssg_pkg::REG_COOLDOWN_MK: prdata = {{(32-rssg_pkg::MASK_W){1'b0}}, cfg_q.cooldown_mask};
			default:                   prdata = '0;
		endcase
	end

endmodule

@@ src/rssg_ctrl.sv @@
module rssg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  rssg_pkg::cfg_t cfg,
	rssg_cmd_if.sink       cmd,
	rssg_res_if.source     res
);

	localparam int N  = rssg_pkg::NUM_RELAYS;
	localparam int IW = rssg_pkg::IDX_W;

	rssg_pkg::state_t state_q, state_d;

	logic        active_q [N];
	logic [7:0]  count_q  [N];
	logic [31:0] wstart_q [N];
	logic        lflag_q  [N];
	logic [31:0] lstart_q [N];
	logic        cflag_q  [N];
	logic [31:0] cstart_q [N];

	logic        func_q;
	logic [3:0]  idx_q;
	logic        on_q;
	logic        force_q;
	logic [31:0] now_q;

	rssg_pkg::status_t status_q;
	logic              acc_q;
	logic [31:0]       el_q;
	logic [31:0]       left_q;

	logic              res_valid_q;
	logic              res_acc_q;
	rssg_pkg::status_t res_status_q;
	logic [3:0]        res_on_q;
	logic [31:0]       res_left_q;
	logic [7:0]        res_count_q;

	rssg_pkg::alu_req_t alu_req;
	rssg_pkg::alu_rsp_t alu_rsp;

	logic [IW-1:0] ri;
	logic          idx_ok;
	logic          need_cd;
	logic [8:0]    lock_limit;
	logic          out_free;
	logic [3:0]    on_bits;

	rssg_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign ri         = idx_q[IW-1:0];
	assign idx_ok     = {1'b0, idx_q} < 5'(N);
	assign need_cd    = rssg_pkg::needs_cd(cfg.cooldown_mask, {1'b0, idx_q});
	assign lock_limit = {1'b0, cfg.max_cycles} + {1'b0, cfg.manual_allowance};
	assign out_free   = !res_valid_q || res.ready;

	assign cmd.ready            = (state_q == rssg_pkg::S_IDLE);
	assign res.valid            = res_valid_q;
	assign res.accepted         = res_acc_q;
	assign res.status           = res_status_q;
	assign res.relays_on        = res_on_q;
	assign res.cooldown_left_ms = res_left_q;
	assign res.turn_on_count    = res_count_q;

	always_comb begin
		on_bits = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < N)
				on_bits[i] = active_q[IW'(i)];
		end
	end

	// shared subtract/compare operand select
	always_comb begin
		alu_req.a   = now_q;
		alu_req.b   = '0;
		alu_req.lim = '0;
		case (state_q)
			rssg_pkg::S_LOCK: begin
				alu_req.b   = lstart_q[ri];
				alu_req.lim = cfg.lockout_ms;
			end
			rssg_pkg::S_WIN1, rssg_pkg::S_WIN2, rssg_pkg::S_ON_WIN: begin
				alu_req.b   = wstart_q[ri];
				alu_req.lim = cfg.window_ms;
			end
			rssg_pkg::S_COOL, rssg_pkg::S_CD1: begin
				alu_req.b   = cstart_q[ri];
				alu_req.lim = cfg.cooldown_ms;
			end
			rssg_pkg::S_CD2: begin
				alu_req.a = cfg.cooldown_ms;
				alu_req.b = el_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rssg_pkg::S_IDLE:
				if (cmd.valid) state_d = rssg_pkg::S_DISPATCH;
			rssg_pkg::S_DISPATCH: begin
				if (func_q)
					state_d = idx_ok ? rssg_pkg::S_CD1 : rssg_pkg::S_DONE;
				else if (!idx_ok)
					state_d = rssg_pkg::S_DONE;
				else if (active_q[ri] == on_q || !on_q)
					state_d = rssg_pkg::S_CD1;
				else if (force_q)
					state_d = rssg_pkg::S_ON_WIN;
				else
					state_d = rssg_pkg::S_LOCK;
			end
			rssg_pkg::S_LOCK:
				state_d = (lflag_q[ri] && alu_rsp.lt) ? rssg_pkg::S_CD1 : rssg_pkg::S_WIN1;
			rssg_pkg::S_WIN1:
				state_d = rssg_pkg::S_LIMIT;
			rssg_pkg::S_LIMIT:
				state_d = ({1'b0, count_q[ri]} >= lock_limit) ? rssg_pkg::S_CD1 : rssg_pkg::S_COOL;
			rssg_pkg::S_COOL:
				state_d = (need_cd && cflag_q[ri] && alu_rsp.lt) ? rssg_pkg::S_CD1
					: rssg_pkg::S_WIN2;
			rssg_pkg::S_WIN2:
				state_d = rssg_pkg::S_MAXC;
			rssg_pkg::S_MAXC:
				state_d = (count_q[ri] >= cfg.max_cycles) ? rssg_pkg::S_CD1 : rssg_pkg::S_ON_WIN;
			rssg_pkg::S_ON_WIN:
				state_d = rssg_pkg::S_ON_SET;
			rssg_pkg::S_ON_SET:
				state_d = rssg_pkg::S_CD1;
			rssg_pkg::S_CD1:
				state_d = (cflag_q[ri] && alu_rsp.lt) ? rssg_pkg::S_CD2 : rssg_pkg::S_DONE;
			rssg_pkg::S_CD2:
				state_d = rssg_pkg::S_DONE;
			rssg_pkg::S_DONE:
				if (out_free) state_d = rssg_pkg::S_IDLE;
			default:
				state_d = rssg_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rssg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_q  <= cmd.func;
			idx_q   <= cmd.relay_index;
			on_q    <= cmd.turn_on;
			force_q <= cmd.force_req;
			now_q   <= cmd.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				active_q[i] <= 1'b0;
				count_q[i]  <= '0;
				wstart_q[i] <= '0;
				lflag_q[i]  <= 1'b0;
				lstart_q[i] <= '0;
				cflag_q[i]  <= 1'b0;
				cstart_q[i] <= '0;
			end
			status_q     <= rssg_pkg::ST_OK;
			acc_q        <= 1'b0;
			el_q         <= '0;
			left_q       <= '0;
			res_valid_q  <= 1'b0;
			res_acc_q    <= 1'b0;
			res_status_q <= rssg_pkg::ST_OK;
			res_on_q     <= '0;
			res_left_q   <= '0;
			res_count_q  <= '0;
		end else begin
			if (res_valid_q && res.ready && state_q != rssg_pkg::S_DONE)
				res_valid_q <= 1'b0;
			case (state_q)
				rssg_pkg::S_DISPATCH: begin
					status_q <= rssg_pkg::ST_OK;
					acc_q    <= 1'b1;
					left_q   <= '0;
					if (func_q) begin
						for (int i = 0; i < N; i++) begin
							active_q[i] <= 1'b0;
							if (rssg_pkg::needs_cd(cfg.cooldown_mask, 5'(i))) begin
								cflag_q[i]  <= 1'b1;
								cstart_q[i] <= now_q;
							end
						end
					end else if (!idx_ok) begin
						status_q <= rssg_pkg::ST_BAD_INDEX;
						acc_q    <= 1'b0;
					end else if (active_q[ri] != on_q && !on_q) begin
						active_q[ri] <= 1'b0;
						if (need_cd) begin
							cflag_q[ri]  <= 1'b1;
							cstart_q[ri] <= now_q;
						end
					end
				end
				rssg_pkg::S_LOCK: begin
					if (lflag_q[ri]) begin
						if (alu_rsp.lt) begin
							status_q <= rssg_pkg::ST_LOCK_ACTIVE;
							acc_q    <= 1'b0;
						end else begin
							count_q[ri]  <= '0;
							wstart_q[ri] <= now_q;
							lflag_q[ri]  <= 1'b0;
						end
					end
				end
				rssg_pkg::S_WIN1, rssg_pkg::S_WIN2, rssg_pkg::S_ON_WIN: begin
					if (!alu_rsp.lt) begin
						wstart_q[ri] <= now_q;
						count_q[ri]  <= '0;
					end
				end
				rssg_pkg::S_LIMIT: begin
					if ({1'b0, count_q[ri]} >= lock_limit) begin
						lflag_q[ri]  <= 1'b1;
						lstart_q[ri] <= now_q;
						status_q     <= rssg_pkg::ST_LOCK_TRIG;
						acc_q        <= 1'b0;
					end
				end
				rssg_pkg::S_COOL: begin
					if (need_cd && cflag_q[ri]) begin
						if (alu_rsp.lt) begin
							status_q <= rssg_pkg::ST_COOLDOWN;
							acc_q    <= 1'b0;
						end else begin
							cflag_q[ri] <= 1'b0;
						end
					end
				end
				rssg_pkg::S_MAXC: begin
					if (count_q[ri] >= cfg.max_cycles) begin
						status_q <= rssg_pkg::ST_CYCLE_LIMIT;
						acc_q    <= 1'b0;
					end
				end
				rssg_pkg::S_ON_SET: begin
					active_q[ri] <= 1'b1;
					if (count_q[ri] != 8'hFF)
						count_q[ri] <= count_q[ri] + 8'd1;
				end
				rssg_pkg::S_CD1: begin
					if (cflag_q[ri]) begin
						if (alu_rsp.lt)
							el_q <= alu_rsp.diff;
						else
							cflag_q[ri] <= 1'b0;
					end
				end
				rssg_pkg::S_CD2: begin
					left_q <= alu_rsp.diff;
				end
				rssg_pkg::S_DONE: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_acc_q    <= acc_q;
						res_status_q <= status_q;
						res_on_q     <= on_bits;
						res_left_q   <= left_q;
						res_count_q  <= idx_ok ? count_q[ri] : 8'd0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ src/relay_switch_safety_guard.sv @@
// Relay command guard. Takes one command at a time on cmd and returns one
// result on res; cmd.ready is low while a command is in work. cmd.ready
// returns in the same cycle that the result becomes valid on res, and a
// single 32-bit subtract/compare unit checks lockout, window and cooldown
// timing one step per cycle, so an unforced turn-on that passes every check
// is the longest path. The result sits in an output register, so a finished
// result may wait on res.ready while the next command is accepted.
// Registers are written over the APB port at 4*index and read back there.
module relay_switch_safety_guard (
	input  logic                         clk,
	input  logic                         arst_n,
	rssg_cmd_if.sink                     cmd,
	rssg_res_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rssg_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	rssg_pkg::cfg_t cfg;

	rssg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rssg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.res    (res)
	);

endmodule

@@ test/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NR             = rssg_pkg::NUM_RELAYS;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic FN_SET       = 1'b0;
	localparam logic FN_ALL_OFF   = 1'b1;

	typedef struct packed {
		logic        func;
		logic [3:0]  idx;
		logic        on;
		logic        frc;
		logic [31:0] stamp;
	} guard_cmd_t;

	typedef struct packed {
		logic              accepted;
		rssg_pkg::status_t status;
		logic [3:0]        relays_on;
		logic [31:0]       cd_left;
		logic [7:0]        count;
	} guard_res_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [rssg_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rssg_cmd_if cmd_bus ();
	rssg_res_if res_bus ();

	relay_switch_safety_guard i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// guard state mirror
	rssg_pkg::cfg_t m_cfg;
	logic [NR-1:0]  m_on;
	logic [NR-1:0]  m_lock;
	logic [NR-1:0]  m_cd;
	logic [7:0]     m_count [NR];
	logic [31:0]    m_win [NR];
	logic [31:0]    m_lock_t [NR];
	logic [31:0]    m_cd_t [NR];

	guard_res_t  guard_expect_q [$];
	int          err_cnt;
	int          idle_cycles;
	int unsigned sink_stall;
	bit          no_idle;
	logic [31:0] t_now;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void guard_clear();
		m_cfg.lockout_ms       = rssg_pkg::RST_LOCKOUT_MS;
		m_cfg.window_ms        = rssg_pkg::RST_WINDOW_MS;
		m_cfg.max_cycles       = rssg_pkg::RST_MAX_CYCLES;
		m_cfg.manual_allowance = rssg_pkg::RST_MANUAL_ALW;
		m_cfg.cooldown_ms      = rssg_pkg::RST_COOLDOWN_MS;
		m_cfg.cooldown_mask    = rssg_pkg::RST_COOLDOWN_MK;
		m_on   = '0;
		m_lock = '0;
		m_cd   = '0;
		for (int i = 0; i < NR; i++) begin
			m_count[i]  = '0;
			m_win[i]    = '0;
			m_lock_t[i] = '0;
			m_cd_t[i]   = '0;
		end
	endfunction

	function automatic logic masked_cd(int r);
		return (r < 4) && m_cfg.cooldown_mask[r];
	endfunction

	function automatic void roll_window(int r, logic [31:0] stamp);
		logic [31:0] el;
		el = stamp - m_win[r];
		if (el >= m_cfg.window_ms) begin
			m_win[r]   = stamp;
			m_count[r] = '0;
		end
	endfunction

	function automatic rssg_pkg::status_t switch_relay(int r, logic on, logic frc,
			logic [31:0] stamp);
		logic [8:0]  limit;
		logic [31:0] el;
		if (on && !frc) begin
			if (m_lock[r]) begin
				el = stamp - m_lock_t[r];
				if (el < m_cfg.lockout_ms)
					return rssg_pkg::ST_LOCK_ACTIVE;
				m_count[r] = '0;
				m_win[r]   = stamp;
				m_lock[r]  = 1'b0;
			end
			roll_window(r, stamp);
			limit = {1'b0, m_cfg.max_cycles} + {1'b0, m_cfg.manual_allowance};
			if ({1'b0, m_count[r]} >= limit) begin
				m_lock[r]   = 1'b1;
				m_lock_t[r] = stamp;
				return rssg_pkg::ST_LOCK_TRIG;
			end
			if (masked_cd(r) && m_cd[r]) begin
				el = stamp - m_cd_t[r];
				if (el < m_cfg.cooldown_ms)
					return rssg_pkg::ST_COOLDOWN;
				m_cd[r] = 1'b0;
			end
			roll_window(r, stamp);
			if (m_count[r] >= m_cfg.max_cycles)
				return rssg_pkg::ST_CYCLE_LIMIT;
		end
		if (on) begin
			m_on[r] = 1'b1;
			roll_window(r, stamp);
			if (m_count[r] != 8'hFF)
				m_count[r] = m_count[r] + 8'd1;
		end else begin
			m_on[r] = 1'b0;
			if (masked_cd(r)) begin
				m_cd[r]   = 1'b1;
				m_cd_t[r] = stamp;
			end
		end
		return rssg_pkg::ST_OK;
	endfunction

	function automatic guard_res_t predict_guard(guard_cmd_t c);
		guard_res_t  rs;
		logic [31:0] el;
		int          r;
		logic        ok_idx;
		r           = int'(c.idx);
		ok_idx      = (r < NR);
		rs.accepted = 1'b1;
		rs.status   = rssg_pkg::ST_OK;
		if (c.func == FN_ALL_OFF) begin
			for (int i = 0; i < NR; i++) begin
				m_on[i] = 1'b0;
				if (masked_cd(i)) begin
					m_cd[i]   = 1'b1;
					m_cd_t[i] = c.stamp;
				end
			end
		end else if (!ok_idx) begin
			rs.accepted = 1'b0;
			rs.status   = rssg_pkg::ST_BAD_INDEX;
		end else if (m_on[r] != c.on) begin
			rs.status   = switch_relay(r, c.on, c.frc, c.stamp);
			rs.accepted = (rs.status == rssg_pkg::ST_OK);
		end
		rs.relays_on = '0;
		for (int i = 0; i < NR && i < 4; i++)
			rs.relays_on[i] = m_on[i];
		rs.cd_left = '0;
		rs.count   = '0;
		if (ok_idx) begin
			if (m_cd[r]) begin
				el = c.stamp - m_cd_t[r];
				if (el >= m_cfg.cooldown_ms)
					m_cd[r] = 1'b0;
				else
					rs.cd_left = m_cfg.cooldown_ms - el;
			end
			rs.count = m_count[r];
		end
		return rs;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			err_cnt++;
		end
	endfunction

	function automatic int unsigned gap_len();
		int unsigned p;
		if (no_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	task automatic send_cmd(input logic func, input logic [3:0] idx, input logic on,
			input logic frc, input logic [31:0] stamp);
		guard_cmd_t  c;
		int unsigned gap;
		c   = '{func, idx, on, frc, stamp};
		gap = gap_len();
		@(negedge clk);
		if (gap != 0) begin
			cmd_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_bus.valid       = 1'b1;
		cmd_bus.func        = func;
		cmd_bus.relay_index = idx;
		cmd_bus.turn_on     = on;
		cmd_bus.force_req   = frc;
		cmd_bus.now_ms      = stamp;
		do @(posedge clk); while (!cmd_bus.ready);
		guard_expect_q.push_back(predict_guard(c));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		cmd_bus.valid = 1'b0;
		while (guard_expect_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_cycle(input rssg_pkg::reg_idx_t idx, input logic wr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic write_reg(rssg_pkg::reg_idx_t idx, logic [31:0] val);
		logic [31:0] unused;
		apb_cycle(idx, 1'b1, val, unused);
		case (idx)
			rssg_pkg::REG_LOCKOUT_MS:  m_cfg.lockout_ms       = val;
			rssg_pkg::REG_WINDOW_MS:   m_cfg.window_ms        = val;
			rssg_pkg::REG_MAX_CYCLES:  m_cfg.max_cycles       = val[7:0];
			rssg_pkg::REG_MANUAL_ALW:  m_cfg.manual_allowance = val[7:0];
			rssg_pkg::REG_COOLDOWN_MS: m_cfg.cooldown_ms      = val;
			default:                   m_cfg.cooldown_mask    = val[rssg_pkg::MASK_W-1:0];
		endcase
	endtask

	task automatic set_config(logic [31:0] lock, logic [31:0] win, logic [7:0] maxc,
			logic [7:0] allow, logic [31:0] cd, logic [3:0] mask);
		wait_idle();
		write_reg(rssg_pkg::REG_LOCKOUT_MS, lock);
		write_reg(rssg_pkg::REG_WINDOW_MS, win);
		write_reg(rssg_pkg::REG_MAX_CYCLES, 32'(maxc));
		write_reg(rssg_pkg::REG_MANUAL_ALW, 32'(allow));
		write_reg(rssg_pkg::REG_COOLDOWN_MS, cd);
		write_reg(rssg_pkg::REG_COOLDOWN_MK, 32'(mask));
	endtask

	task automatic test_reg_readback();
		rssg_pkg::reg_idx_t ri;
		logic [31:0]        got;
		logic [31:0]        want;
		wait_idle();
		ri = ri.first();
		do begin
			apb_cycle(ri, 1'b0, '0, got);
			case (ri)
				rssg_pkg::REG_LOCKOUT_MS:  want = m_cfg.lockout_ms;
				rssg_pkg::REG_WINDOW_MS:   want = m_cfg.window_ms;
				rssg_pkg::REG_MAX_CYCLES:  want = 32'(m_cfg.max_cycles);
				rssg_pkg::REG_MANUAL_ALW:  want = 32'(m_cfg.manual_allowance);
				rssg_pkg::REG_COOLDOWN_MS: want = m_cfg.cooldown_ms;
				default:                   want = 32'(m_cfg.cooldown_mask);
			endcase
			check_field(ri.name(), want, got);
			ri = ri.next();
		end while (ri != ri.first());
	endtask

	task automatic test_directed_guard();
		// bad indices, all-off, repeats, wrapping timestamps
		send_cmd(FN_SET, 4'd4, 1'b1, 1'b0, 32'd0);
		send_cmd(FN_SET, 4'd15, 1'b0, 1'b1, 32'd0);
		send_cmd(FN_ALL_OFF, 4'd2, 1'b0, 1'b0, 32'd100);
		send_cmd(FN_ALL_OFF, 4'd9, 1'b1, 1'b1, 32'd100);
		send_cmd(FN_SET, 4'd0, 1'b1, 1'b0, 32'd0);
		send_cmd(FN_SET, 4'd0, 1'b1, 1'b0, 32'd1);
		send_cmd(FN_SET, 4'd0, 1'b0, 1'b0, 32'd2);
		send_cmd(FN_SET, 4'd3, 1'b1, 1'b1, 32'hFFFF_FFF0);
		send_cmd(FN_SET, 4'd3, 1'b0, 1'b0, 32'h0000_0010);
		send_cmd(FN_SET, 4'd3, 1'b1, 1'b0, 32'h0000_0020);

		// guard checks on relays 1 and 2 with short timers
		set_config(32'd100, 32'd1000, 8'd1, 8'd1, 32'd300, 4'b0010);
		send_cmd(FN_SET, 4'd1, 1'b1, 1'b0, 32'd10);
		send_cmd(FN_SET, 4'd1, 1'b0, 1'b0, 32'd20);
		send_cmd(FN_SET, 4'd1, 1'b1, 1'b0, 32'd30);
		send_cmd(FN_SET, 4'd1, 1'b1, 1'b1, 32'd40);
		send_cmd(FN_SET, 4'd1, 1'b0, 1'b0, 32'd50);
		send_cmd(FN_SET, 4'd1, 1'b1, 1'b0, 32'd60);
		send_cmd(FN_SET, 4'd1, 1'b1, 1'b0, 32'd100);
		send_cmd(FN_SET, 4'd1, 1'b1, 1'b0, 32'd400);
		send_cmd(FN_SET, 4'd1, 1'b0, 1'b0, 32'd410);
		send_cmd(FN_ALL_OFF, 4'd1, 1'b0, 1'b0, 32'd500);
		send_cmd(FN_SET, 4'd2, 1'b1, 1'b0, 32'd600);
		send_cmd(FN_SET, 4'd1, 1'b1, 1'b1, 32'd800);
		send_cmd(FN_SET, 4'd1, 1'b1, 1'b0, 32'd900);
		send_cmd(FN_SET, 4'd2, 1'b0, 1'b0, 32'd610);
		send_cmd(FN_SET, 4'd2, 1'b1, 1'b0, 32'd620);
	endtask

	task automatic run_guard_traffic(int n_items, int unsigned step_max);
		int unsigned p;
		logic        func;
		logic [3:0]  idx;
		logic        on;
		for (int k = 0; k < n_items; k++) begin
			no_idle = ((k / 40) % 4 == 1);
			p = $urandom_range(0, 99);
			if (p < 5)
				t_now = $urandom;
			else if (p < 75)
				t_now = t_now + $urandom_range(1, step_max);
			else if (p < 90)
				t_now = t_now + $urandom_range(step_max, 6 * step_max);
			p    = $urandom_range(0, 99);
			func = (p < 4) ? FN_ALL_OFF : FN_SET;
			if (p < 12)
				idx = 4'($urandom_range(0, 15));
			else
				idx = 4'($urandom_range(0, NR - 1));
			if (idx < NR && $urandom_range(0, 9) < 7)
				on = !m_on[idx];
			else
				on = 1'($urandom_range(0, 1));
			send_cmd(func, idx, on, $urandom_range(0, 99) < 15, t_now);
		end
		no_idle = 1'b0;
	endtask

	task automatic relay0_toggles(int n_items);
		for (int k = 0; k < n_items; k++) begin
			t_now = t_now + $urandom_range(0, 3);
			if ($urandom_range(0, 19) == 0)
				send_cmd(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t_now);
			else
				send_cmd(FN_SET, 4'd0, !m_on[0], 1'($urandom_range(0, 1)), t_now);
		end
	endtask

	task automatic test_count_saturation();
		// count runs into 255 under a window that never closes
		set_config(32'd10, 32'hFFFF_FFFF, 8'd255, 8'd255, 32'd0, 4'b0001);
		relay0_toggles(560);
		// threshold of exactly 255 now trips the lockout
		set_config(32'd10, 32'hFFFF_FFFF, 8'd255, 8'd0, 32'd0, 4'b0001);
		relay0_toggles(20);
	endtask

	task automatic test_random_phases();
		set_config(32'd5000, 32'd60000, 8'd6, 8'd2, 32'd180000, 4'($urandom_range(0, 15)));
		run_guard_traffic(150, 2500);
		set_config(32'd40, 32'd200, 8'd3, 8'd2, 32'd60, 4'hF);
		run_guard_traffic(150, 15);
		set_config('1, '1, 8'hFF, 8'hFF, '1, 4'hF);
		run_guard_traffic(150, 100000);
		set_config(32'd0, 32'd1, 8'd0, 8'd0, 32'd0, 4'hF);
		run_guard_traffic(150, 2);
		set_config(32'd30, 32'd0, 8'd2, 8'd1, 32'd50, 4'h5);
		run_guard_traffic(150, 10);
		repeat (3) begin
			set_config($urandom_range(0, 500), $urandom_range(1, 2000),
				8'($urandom_range(0, 8)), 8'($urandom_range(0, 4)),
				$urandom_range(0, 500), 4'($urandom_range(0, 15)));
			run_guard_traffic(150, 40);
		end
	endtask

	always @(negedge clk) begin
		if (sink_stall != 0) begin
			res_bus.ready = 1'b0;
			sink_stall--;
		end else begin
			res_bus.ready = 1'b1;
			if ($urandom_range(0, 2) == 0)
				sink_stall = gap_len();
		end
	end

	always @(posedge clk) begin : res_check
		guard_res_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (guard_expect_q.size() == 0) begin
				$display("%0t: result with no command pending", $time);
				err_cnt++;
			end else begin
				want = guard_expect_q.pop_front();
				check_field("accepted", 32'(want.accepted), 32'(res_bus.accepted));
				check_field("status", 32'(want.status), 32'(res_bus.status));
				check_field("relays_on", 32'(want.relays_on), 32'(res_bus.relays_on));
				check_field("cooldown_left_ms", want.cd_left, res_bus.cooldown_left_ms);
				check_field("turn_on_count", 32'(want.count), 32'(res_bus.turn_on_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)
				|| (psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.func        = FN_SET;
		cmd_bus.relay_index = '0;
		cmd_bus.turn_on     = 1'b0;
		cmd_bus.force_req   = 1'b0;
		cmd_bus.now_ms      = '0;
		res_bus.ready       = 1'b0;
		sink_stall          = 0;
		no_idle             = 1'b0;
		err_cnt             = 0;
		idle_cycles         = 0;
		t_now               = '0;
		guard_clear();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reg_readback();
		test_directed_guard();
		test_count_saturation();
		test_random_phases();
		test_reg_readback();

		wait_idle();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
